>>> design/scs_pkg.sv
// Shared types and constants for the Shi-Tomasi corner score block.
`timescale 1ns / 1ps
package scs_pkg;

	localparam int WIN_COLS   = 9;
	localparam int WIN_ROWS   = 7;
	localparam int ACC_STEPS  = 7;
	localparam int ROOT_STEPS = 24;
	localparam int CNT_W      = 5;
	localparam int ADDR_W     = 3;

	localparam logic [11:0] IMAGE_WIDTH_RST = 12'd640;
	localparam logic [15:0] SCORE_GAIN_RST  = 16'd1311;

	typedef enum logic {
		REG_IMAGE_WIDTH = 1'b0,
		REG_SCORE_GAIN  = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic       start_of_frame;
	} scs_in_t;

	typedef struct packed {
		logic [30:0] corner_score;
		logic [10:0] center_x;
		logic [10:0] center_y;
		logic        window_valid;
	} scs_out_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_ACC,
		ST_SQ1,
		ST_SQ2,
		ST_RINIT,
		ST_ROOT,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic load;
		logic acc;
		logic sq1;
		logic sq2;
		logic rinit;
		logic root;
		logic mul;
		logic out_load;
	} scs_cmd_t;

	typedef struct packed {
		logic win_ok;
		logic clr_last;
	} scs_sts_t;

endpackage

>>> design/scs_dp.sv
// Datapath: line store, pixel window, gradient sums, square root and scaling.
`timescale 1ns / 1ps
module scs_dp #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scs_pkg::scs_in_t  in_data,
	input  logic [11:0]       image_width,
	input  logic [15:0]       score_gain,
	input  scs_pkg::scs_cmd_t cmd,
	output scs_pkg::scs_sts_t sts,
	output scs_pkg::scs_out_t out_data
);
	import scs_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] col_q, col_base, col_cur, col_lat_q, clr_q;
	logic [RW-1:0] row_q, row_cur, row_lat_q;
	logic [CW:0]   eff_w, col_nx;
	logic [31:0]   iw32, eff32, cx32, cy32;
	logic          wrap, win_ok_q;
	logic [7:0]    pix_q;
	logic [47:0]   rd_q;
	logic [47:0]   mem [MAX_WIDTH];

	logic [7:0] win_q [WIN_ROWS][WIN_COLS];
	logic [7:0] wrk_q [WIN_ROWS][WIN_COLS];
	logic [7:0] win_nx [WIN_ROWS][WIN_COLS];

	logic signed [22:0] sxx_q, syy_q, sxy_q, sum_xx, sum_yy, sum_xy, diff;
	logic signed [8:0]  dx [5];
	logic signed [8:0]  dy [5];
	logic signed [45:0] dsq_full, xsq_full;
	logic [45:0] dsq_q, xsq_q;
	logic [47:0] rem_q, root_q, bit_q, trial;
	logic [24:0] t_ext, d_val;
	logic [38:0] prod;
	logic [30:0] score_q;
	scs_out_t    out_q;

	assign iw32  = {20'd0, image_width};
	assign eff32 = (iw32 < 32'd9) ? 32'd9 :
		((iw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : iw32);
	assign eff_w = eff32[CW:0];

	assign col_base = in_data.start_of_frame ? '0 : col_q;
	assign col_cur  = ({1'b0, col_base} >= eff_w) ? '0 : col_base;
	assign row_cur  = in_data.start_of_frame ? '0 : row_q;
	assign col_nx   = {1'b0, col_cur} + 1'b1;
	assign wrap     = col_nx >= eff_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			col_q <= wrap ? '0 : col_nx[CW-1:0];
			if (wrap && (32'(row_cur) < 32'(MAX_HEIGHT - 1)))
				row_q <= row_cur + 1'b1;
			else
				row_q <= row_cur;
		end
	end

	// Address of the clearing pass that zeroes the line store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear)
			clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_lat_q <= col_cur;
			row_lat_q <= row_cur;
			pix_q     <= in_data.pixel_value;
			win_ok_q  <= (32'(col_cur) >= 32'd8) && (32'(row_cur) >= 32'd6);
		end
	end

	// Line store: read at accept, written back in the load state with the new pixel.
	always_ff @(posedge clk) begin
		if (cmd.accept)
			rd_q <= mem[col_cur];
		if (cmd.clear)
			mem[clr_q] <= '0;
		else if (cmd.load)
			mem[col_lat_q] <= {rd_q[39:0], pix_q};
	end

	always_comb begin
		for (int j = 0; j < WIN_ROWS; j++) begin
			for (int i = 0; i < WIN_COLS - 1; i++)
				win_nx[j][i] = win_q[j][i + 1];
		end
		for (int j = 0; j < WIN_ROWS - 1; j++)
			win_nx[j][WIN_COLS - 1] = rd_q[8 * (5 - j) +: 8];
		win_nx[WIN_ROWS - 1][WIN_COLS - 1] = pix_q;
	end

	// The work copy slides left each step so the gradients are always taken
	// from its first three columns.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q <= win_nx;
			wrk_q <= win_nx;
		end else if (cmd.acc) begin
			for (int j = 0; j < WIN_ROWS; j++) begin
				for (int i = 0; i < WIN_COLS - 1; i++)
					wrk_q[j][i] <= wrk_q[j][i + 1];
				wrk_q[j][WIN_COLS - 1] <= 8'd0;
			end
		end
	end

	always_comb begin
		sum_xx = sxx_q;
		sum_yy = syy_q;
		sum_xy = sxy_q;
		for (int j = 0; j < 5; j++) begin
			dx[j] = $signed({1'b0, wrk_q[j + 1][2]}) - $signed({1'b0, wrk_q[j + 1][0]});
			dy[j] = $signed({1'b0, wrk_q[j + 2][1]}) - $signed({1'b0, wrk_q[j][1]});
			sum_xx = sum_xx + 23'(dx[j] * dx[j]);
			sum_yy = sum_yy + 23'(dy[j] * dy[j]);
			sum_xy = sum_xy + 23'(dx[j] * dy[j]);
		end
	end

	assign diff     = sxx_q - syy_q;
	assign dsq_full = diff * diff;
	assign xsq_full = sxy_q * sxy_q;
	assign trial    = root_q + bit_q;
	assign t_ext    = 25'(sxx_q) + 25'(syy_q);
	assign d_val    = (t_ext > root_q[24:0]) ? t_ext - root_q[24:0] : 25'd0;
	assign prod     = d_val[22:0] * score_gain;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end else if (cmd.acc) begin
			sxx_q <= sum_xx;
			syy_q <= sum_yy;
			sxy_q <= sum_xy;
		end
		if (cmd.sq1)
			dsq_q <= dsq_full;
		if (cmd.sq2)
			xsq_q <= xsq_full;
		if (cmd.rinit) begin
			rem_q  <= 48'(dsq_q) + {xsq_q, 2'b00};
			root_q <= '0;
			bit_q  <= 48'h1 << 46;
		end else if (cmd.root) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.mul)
			score_q <= prod[38:8];
	end

	assign cx32 = 32'(col_lat_q) - 32'd4;
	assign cy32 = 32'(row_lat_q) - 32'd3;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.corner_score <= win_ok_q ? score_q : '0;
			out_q.center_x     <= win_ok_q ? cx32[10:0] : '0;
			out_q.center_y     <= win_ok_q ? cy32[10:0] : '0;
			out_q.window_valid <= win_ok_q;
		end
	end

	assign out_data     = out_q;
	assign sts.win_ok   = win_ok_q;
	assign sts.clr_last = clr_q == CW'(MAX_WIDTH - 1);

endmodule

>>> design/scs_ctrl.sv
// Controller state machine sequencing one pixel through the datapath.
`timescale 1ns / 1ps
module scs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  scs_pkg::scs_sts_t sts,
	output scs_pkg::scs_cmd_t cmd
);
	import scs_pkg::*;

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_ACC || state_q == ST_ROOT) begin
			cnt_q <= cnt_q + 1'b1;
		end else begin
			cnt_q <= '0;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clr_last) state_nx = ST_IDLE;
			ST_IDLE:  if (in_valid) state_nx = ST_READ;
			ST_READ:  state_nx = ST_LOAD;
			ST_LOAD:  state_nx = sts.win_ok ? ST_ACC : ST_OUT;
			ST_ACC:   if (cnt_q == CNT_W'(ACC_STEPS - 1)) state_nx = ST_SQ1;
			ST_SQ1:   state_nx = ST_SQ2;
			ST_SQ2:   state_nx = ST_RINIT;
			ST_RINIT: state_nx = ST_ROOT;
			ST_ROOT:  if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_nx = ST_MUL;
			ST_MUL:   state_nx = ST_OUT;
			ST_OUT:   if (!out_valid_q || out_ready) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.clear    = state_q == ST_CLEAR;
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.load     = state_q == ST_LOAD;
		cmd.acc      = state_q == ST_ACC;
		cmd.sq1      = state_q == ST_SQ1;
		cmd.sq2      = state_q == ST_SQ2;
		cmd.rinit    = state_q == ST_RINIT;
		cmd.root     = state_q == ST_ROOT;
		cmd.mul      = state_q == ST_MUL;
		cmd.out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROOT |-> cnt_q < CNT_W'(ROOT_STEPS))
		else $error("root step count overran");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result beat overwritten before taken");

	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_LOAD)
		else $error("line store read not followed by load");

endmodule

>>> design/shi_tomasi_corner_score.sv
// Pixels are handled one at a time: the next is taken only after the last one
// has reached the output register. A window inside the image runs 7 accumulate
// steps and 24 square-root steps; other pixels skip both. The output register
// lets the next pixel be taken while a result waits. Reset clears counters and
// control and starts a pass that zeroes the line store before any input.
`timescale 1ns / 1ps
module shi_tomasi_corner_score #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  scs_pkg::scs_in_t            in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output scs_pkg::scs_out_t           out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [scs_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import scs_pkg::*;

	logic [11:0] image_width_q;
	logic [15:0] score_gain_q;
	reg_sel_t    sel;
	scs_cmd_t    cmd;
	scs_sts_t    sts;

	assign sel    = reg_sel_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			score_gain_q  <= SCORE_GAIN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (sel)
				REG_IMAGE_WIDTH: image_width_q <= pwdata[11:0];
				REG_SCORE_GAIN:  score_gain_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_IMAGE_WIDTH: prdata = {20'd0, image_width_q};
			REG_SCORE_GAIN:  prdata = {16'd0, score_gain_q};
			default:         prdata = '0;
		endcase
	end

	scs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	scs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.image_width (image_width_q),
		.score_gain  (score_gain_q),
		.cmd         (cmd),
		.sts         (sts),
		.out_data    (out_data)
	);

endmodule

>>> tb/scs_checker.sv
// Checker for the corner score block: predicts each result and compares it.
`timescale 1ns / 1ps
module scs_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  scs_pkg::scs_in_t       in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  scs_pkg::scs_out_t      out_data,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [scs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]            pwdata,
	input  logic                   pready,
	output int                     fail_count,
	output int                     pending,
	output int                     scored,
	output int                     valid_scored
);
	import scs_pkg::*;

	localparam int LINE_DEPTH = 2048;
	localparam int ROW_LAST   = 2047;

	bit [11:0] width_reg;
	bit [15:0] gain_reg;
	bit [47:0] line_mem [LINE_DEPTH];
	bit [7:0]  win [WIN_ROWS][WIN_COLS];
	int        col_cnt;
	int        row_cnt;
	scs_out_t  score_q [$];

	function automatic bit [63:0] floor_root(bit [63:0] v);
		bit [63:0] root;
		bit [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic bit [30:0] min_eig_score();
		int sxx, syy, sxy, dx, dy;
		longint diff, disc;
		bit [63:0] t, s, d, prod;
		sxx = 0;
		syy = 0;
		sxy = 0;
		for (int j = 1; j <= 5; j++) begin
			for (int i = 1; i <= 7; i++) begin
				dx = int'(win[j][i+1]) - int'(win[j][i-1]);
				dy = int'(win[j+1][i]) - int'(win[j-1][i]);
				sxx += dx * dx;
				syy += dy * dy;
				sxy += dx * dy;
			end
		end
		diff = longint'(sxx) - longint'(syy);
		disc = diff * diff + 4 * longint'(sxy) * longint'(sxy);
		t = 64'(sxx) + 64'(syy);
		s = floor_root(64'(disc));
		d = (t > s) ? t - s : 64'd0;
		prod = (d * 64'(gain_reg)) >> 8;
		return prod[30:0];
	endfunction

	// Advance the model by one pixel and queue the result it produces.
	task automatic predict_pixel(scs_in_t px);
		int        w;
		bit [47:0] stored;
		scs_out_t  r;
		w = width_reg;
		if (w < 9)
			w = 9;
		if (w > LINE_DEPTH)
			w = LINE_DEPTH;
		if (px.start_of_frame) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		if (col_cnt >= w)
			col_cnt = 0;
		stored = line_mem[col_cnt];
		for (int j = 0; j < WIN_ROWS; j++)
			for (int i = 0; i < WIN_COLS - 1; i++)
				win[j][i] = win[j][i+1];
		for (int j = 0; j < WIN_ROWS - 1; j++)
			win[j][WIN_COLS-1] = stored[8*(5-j) +: 8];
		win[WIN_ROWS-1][WIN_COLS-1] = px.pixel_value;
		line_mem[col_cnt] = {stored[39:0], px.pixel_value};
		r = '0;
		if (col_cnt >= 8 && row_cnt >= 6) begin
			r.corner_score = min_eig_score();
			r.center_x     = 11'(col_cnt - 4);
			r.center_y     = 11'(row_cnt - 3);
			r.window_valid = 1'b1;
		end
		score_q = {score_q, r};
		col_cnt++;
		if (col_cnt >= w) begin
			col_cnt = 0;
			if (row_cnt < ROW_LAST)
				row_cnt++;
		end
	endtask

	initial begin
		width_reg = IMAGE_WIDTH_RST;
		gain_reg = SCORE_GAIN_RST;
		col_cnt = 0;
		row_cnt = 0;
		fail_count = 0;
		scored = 0;
		valid_scored = 0;
		foreach (line_mem[k])
			line_mem[k] = '0;
		foreach (win[j, i])
			win[j][i] = '0;
	end

	assign pending = score_q.size();

	always @(posedge clk) begin
		scs_out_t e;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_IMAGE_WIDTH)
					width_reg = pwdata[11:0];
				else
					gain_reg = pwdata[15:0];
			end
			if (in_valid && in_ready)
				predict_pixel(in_data);
			if (out_valid && out_ready) begin
				if (score_q.size() == 0) begin
					$error("result beat with nothing expected: %p", out_data);
					fail_count++;
				end else begin
					e = score_q.pop_front();
					scored++;
					if (e.window_valid)
						valid_scored++;
					if (out_data.corner_score !== e.corner_score) begin
						$error("corner_score expected %0d actual %0d",
							e.corner_score, out_data.corner_score);
						fail_count++;
					end
					if (out_data.center_x !== e.center_x) begin
						$error("center_x expected %0d actual %0d",
							e.center_x, out_data.center_x);
						fail_count++;
					end
					if (out_data.center_y !== e.center_y) begin
						$error("center_y expected %0d actual %0d",
							e.center_y, out_data.center_y);
						fail_count++;
					end
					if (out_data.window_valid !== e.window_valid) begin
						$error("window_valid expected %0d actual %0d",
							e.window_valid, out_data.window_valid);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

>>> tb/testbench.sv
// Top of the corner score testbench: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module testbench;
	import scs_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	scs_in_t           in_data;
	logic              out_valid;
	logic              out_ready;
	scs_out_t          out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int  fail_count, pending, scored, valid_scored;
	int  pixels_sent;
	int  burst_left;
	bit  hold_req, hold_done;
	int  frames;

	shi_tomasi_corner_score DUT (.*);

	scs_checker checker_i (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .pending, .scored, .valid_scored
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Receiver: picks a new stall pattern after each random span, and once
	// holds off for a long stretch so the block backs up into its input.
	initial begin
		int mode, span;
		out_ready = 1'b0;
		hold_done = 0;
		mode = 0;
		span = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 2);
					span = $urandom_range(50, 300);
				end
				span--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic write_reg(reg_sel_t sel, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// One pixel beat; after it the sender may take a gap between bursts.
	task automatic send_pixel(logic [7:0] pix, logic sof);
		in_valid <= 1'b1;
		in_data  <= '{pixel_value: pix, start_of_frame: sof};
		do
			@(posedge clk);
		while (!in_ready);
		pixels_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [7:0] frame_pixel(int kind, int x, int y);
		case (kind)
			0: return 8'($urandom);
			1: return 8'(x * 17 + y * 29 + $urandom_range(0, 7));
			2: return (((x / 3) + (y / 2)) % 2) ? 8'hFF : 8'h00;
			default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		endcase
	endfunction

	task automatic send_frame(int w, int h, bit with_sof);
		int kind, break_at;
		kind = $urandom_range(0, 3);
		break_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h - 1) : -1;
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				send_pixel(frame_pixel(kind, x, y),
					(x == 0 && y == 0 && with_sof) || (y * w + x == break_at));
		frames++;
	endtask

	initial begin
		int w, h;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		hold_req = 0;
		pixels_sent = 0;
		burst_left = 0;
		frames = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a few pixels, at the field extremes and in alternating bit patterns, start flags mixed.
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'hAA, 1'b0);
		send_pixel(8'h55, 1'b0);
		drain();

		// Width below range clamps to nine; full gain on a nine by nine frame.
		write_reg(REG_IMAGE_WIDTH, 32'd0);
		write_reg(REG_SCORE_GAIN, 32'd65535);
		send_frame(9, 9, 1);
		drain();

		// Width above range clamps to the line store size; zero gain.
		write_reg(REG_IMAGE_WIDTH, 32'd4095);
		write_reg(REG_SCORE_GAIN, 32'd0);
		for (int k = 0; k < 30; k++)
			send_pixel(8'($urandom), k == 0);
		drain();

		write_reg(REG_IMAGE_WIDTH, 32'd9);
		write_reg(REG_SCORE_GAIN, 32'd65535);

		// Long receiver hold while the sender keeps offering pixels.
		hold_req = 1;
		send_frame(9, 8, 1);
		while (!hold_done)
			@(posedge clk);
		drain();

		while (pixels_sent < 1250) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				w = $urandom_range(0, 5) == 0 ? 9 : $urandom_range(9, 18);
				write_reg(REG_IMAGE_WIDTH, w);
				case ($urandom_range(0, 3))
					0: write_reg(REG_SCORE_GAIN, 32'd65535);
					1: write_reg(REG_SCORE_GAIN, 32'd0);
					default: write_reg(REG_SCORE_GAIN, $urandom_range(1, 65534));
				endcase
			end
			w = checker_i.width_reg;
			h = $urandom_range(7, 11);
			send_frame(w < 9 ? 9 : w, h, $urandom_range(0, 9) != 0);
		end

		drain();
		$display("Sent %0d pixels in %0d frames; %0d results checked, %0d inside the window.",
			pixels_sent, frames, scored, valid_scored);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

>>> filelist.f
design/scs_pkg.sv
design/scs_dp.sv
design/scs_ctrl.sv
design/shi_tomasi_corner_score.sv
tb/scs_checker.sv
tb/testbench.sv
